@@ hdl/ptts_pkg.sv @@
// Package: sizes, codes and shared types of the periodic task tick scheduler.
package ptts_pkg;

  localparam int ROWS          = 4;
  localparam int SLOTS_PER_ROW = 4;
  localparam int NSLOT         = ROWS * SLOTS_PER_ROW;
  localparam int MAX_RESULTS   = 16;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] KIND_CREATED  = 2'd0;
  localparam logic [1:0] KIND_ROW_FULL = 2'd1;
  localparam logic [1:0] KIND_DUE      = 2'd2;
  localparam logic [1:0] KIND_IDLE     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } ptts_state_t;

  // Command fanned out to every cell.
  typedef struct packed {
    logic        shift;
    logic [31:0] period;
    logic [31:0] delay;
    logic [7:0]  handler;
  } ptts_cell_cmd_t;

  // Status returned by each cell.
  typedef struct packed {
    logic       ready;
    logic       first_empty;
    logic       due;
    logic [7:0] handler;
  } ptts_cell_st_t;

endpackage

@@ hdl/ptts_if.sv @@
// Interfaces: request channel and result channel of the scheduler.
interface ptts_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [1:0]  priority_req;
  logic [31:0] period;
  logic [31:0] first_delay;
  logic [7:0]  handler;

  modport source (output valid, op, priority_req, period, first_delay, handler,
                  input ready);
  modport sink   (input valid, op, priority_req, period, first_delay, handler,
                  output ready);
endinterface

interface ptts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] row;
  logic [1:0] slot;
  logic [7:0] task_handler;
  logic       last;

  modport source (output valid, kind, row, slot, task_handler, last,
                  input ready);
  modport sink   (input valid, kind, row, slot, task_handler, last,
                  output ready);
endinterface

@@ hdl/ptts_cell.sv @@
// Scheduler cell: one task slot plus its stage of the walk token chain.
module ptts_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ptts_pkg::ptts_cell_cmd_t cmd,
  input  logic                    wr,
  input  logic                    tok_in,
  input  logic                    prev_ready,
  input  logic                    first_in_row,
  output logic                    tok_out,
  output ptts_pkg::ptts_cell_st_t st
);

  logic        ready_r;
  logic        tok_r;
  logic [31:0] period_r;
  logic [31:0] cd_r;
  logic [7:0]  hnd_r;
  logic        visit;
  logic        zero;

  assign zero  = (cd_r == 32'd0);
  assign visit = cmd.shift && tok_r && ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      if (cmd.shift) begin
        tok_r <= tok_in;
      end
      if (wr) begin
        ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      period_r <= cmd.period;
      cd_r     <= cmd.delay;
      hnd_r    <= cmd.handler;
    end else if (visit) begin
      cd_r <= zero ? (period_r - 32'd1) : (cd_r - 32'd1);
    end
  end

  assign tok_out        = tok_r;
  assign st.ready       = ready_r;
  // slots fill from slot 0 up, so the ready slots of a row form a prefix
  assign st.first_empty = !ready_r && (first_in_row || prev_ready);
  assign st.due         = tok_r && ready_r && zero;
  assign st.handler     = hnd_r;

endmodule

@@ hdl/periodic_task_tick_scheduler_top.sv @@
// Top level: periodic task tick scheduler, a chain of slot cells and its walk control.
//
// Usage
//   in_ch  : request channel (op, priority_req, period, first_delay, handler),
//            taken on valid && ready.
//   out_ch : result channel (kind, row, slot, task_handler, last), one or more
//            results per request, last marks the final one.
// Timing
//   A request is taken only when the block is idle and its result register is
//   empty; one request is in progress at a time.
//   Create: one result, shown the cycle after the request is taken.
//   Tick: a token runs down the chain of 16 cells, one cell per cycle while the
//   walk is not stalled, each occupied cell updating its own countdown when the
//   token reaches it; a due task is reported as the token passes. The final
//   result is shown from the finish state, after the token leaves the last
//   cell, and the next request is taken the cycle after it leaves.
// Stalls
//   While out_ch.ready is low a held result stays put; the token stops only
//   when a new due task needs the result register.
// Reset: rst_n (synchronous, active low) empties every slot and returns to idle.
module periodic_task_tick_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  ptts_in_if.sink     in_ch,
  ptts_out_if.source  out_ch
);

  localparam int NS  = ptts_pkg::NSLOT;
  localparam int SPR = ptts_pkg::SLOTS_PER_ROW;

  ptts_pkg::ptts_state_t    state_r, state_nxt;
  ptts_pkg::ptts_cell_cmd_t cmd;
  ptts_pkg::ptts_cell_st_t  st [NS];

  logic [NS-1:0] tok;
  logic [NS-1:0] ready_v;
  logic [NS-1:0] wr_v;
  logic [NS-1:0] row_hit;
  logic [NS-1:0] sel_v;

  logic       in_acc, create_acc, tick_acc;
  logic       in_rdy, walk_en, finish_go, out_free, shift_en;
  logic       due_any, due_rep, push;
  logic [1:0] due_row, due_slot, new_slot;
  logic [7:0] due_hnd;
  logic       row_full;

  logic             out_valid_r;
  logic [1:0]       out_kind_r, out_row_r, out_slot_r;
  logic [7:0]       out_hnd_r;
  logic             out_last_r;
  logic             pend_v_r;
  logic [1:0]       pend_row_r, pend_slot_r;
  logic [7:0]       pend_hnd_r;
  logic [ptts_pkg::CNT_W-1:0] cnt_r;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_acc     = in_ch.valid && in_rdy;
  assign create_acc = in_acc && (in_ch.op == ptts_pkg::OP_CREATE);
  assign tick_acc   = in_acc && (in_ch.op == ptts_pkg::OP_TICK);

  assign cmd.shift   = shift_en;
  assign cmd.period  = in_ch.period;
  assign cmd.delay   = in_ch.first_delay;
  assign cmd.handler = in_ch.handler;

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < NS; i++) begin : g_cell
    logic tin, pr;
    if (i == 0) begin : g_head
      assign tin = tick_acc;
      assign pr  = 1'b0;
    end else begin : g_body
      assign tin = tok[i-1];
      assign pr  = ready_v[i-1];
    end

    assign row_hit[i] = (32'(in_ch.priority_req) == 32'(i / SPR));
    assign sel_v[i]   = row_hit[i] && st[i].first_empty;
    assign wr_v[i]    = create_acc && sel_v[i];
    assign ready_v[i] = st[i].ready;

    ptts_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .wr           (wr_v[i]),
      .tok_in       (tin),
      .prev_ready   (pr),
      .first_in_row ((i % SPR) == 0),
      .tok_out      (tok[i]),
      .st           (st[i])
    );
  end

  // only one cell holds the token and only one is selected, so OR them together
  always_comb begin
    due_any  = 1'b0;
    due_row  = '0;
    due_slot = '0;
    due_hnd  = '0;
    new_slot = '0;
    for (int i = 0; i < NS; i++) begin
      if (st[i].due) begin
        due_any  = 1'b1;
        due_row  = due_row  | 2'((i / SPR) % 4);
        due_slot = due_slot | 2'((i % SPR) % 4);
        due_hnd  = due_hnd  | st[i].handler;
      end
      if (sel_v[i]) begin
        new_slot = new_slot | 2'((i % SPR) % 4);
      end
    end
  end

  assign row_full = !(|sel_v);

  // ---------------------------------------------------------------- control
  assign due_rep = due_any && (cnt_r < ptts_pkg::CNT_W'(ptts_pkg::MAX_RESULTS));
  assign push    = due_rep && pend_v_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptts_pkg::ST_IDLE: begin
        if (tick_acc) state_nxt = ptts_pkg::ST_WALK;
      end
      ptts_pkg::ST_WALK: begin
        if (walk_en && tok[NS-1]) state_nxt = ptts_pkg::ST_FINISH;
      end
      ptts_pkg::ST_FINISH: begin
        if (out_free) state_nxt = ptts_pkg::ST_IDLE;
      end
      default: state_nxt = ptts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy    = 1'b0;
    walk_en   = 1'b0;
    finish_go = 1'b0;
    shift_en  = 1'b1;
    unique case (state_r)
      ptts_pkg::ST_IDLE: begin
        in_rdy = !out_valid_r;
      end
      ptts_pkg::ST_WALK: begin
        walk_en  = !push || out_free;
        shift_en = walk_en;
      end
      ptts_pkg::ST_FINISH: begin
        finish_go = out_free;
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pending due result, held until we know whether it is the final one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      cnt_r    <= '0;
    end else if (tick_acc) begin
      pend_v_r <= 1'b0;
      cnt_r    <= '0;
    end else if (walk_en && due_rep) begin
      pend_v_r <= 1'b1;
      cnt_r    <= cnt_r + ptts_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (walk_en && due_rep) begin
      pend_row_r  <= due_row;
      pend_slot_r <= due_slot;
      pend_hnd_r  <= due_hnd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (create_acc || (walk_en && push) || finish_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (create_acc) begin
      out_kind_r <= row_full ? ptts_pkg::KIND_ROW_FULL : ptts_pkg::KIND_CREATED;
      out_row_r  <= in_ch.priority_req;
      out_slot_r <= row_full ? 2'd0 : new_slot;
      out_hnd_r  <= 8'd0;
      out_last_r <= 1'b1;
    end else if (walk_en && push) begin
      out_kind_r <= ptts_pkg::KIND_DUE;
      out_row_r  <= pend_row_r;
      out_slot_r <= pend_slot_r;
      out_hnd_r  <= pend_hnd_r;
      out_last_r <= 1'b0;
    end else if (finish_go) begin
      out_kind_r <= pend_v_r ? ptts_pkg::KIND_DUE : ptts_pkg::KIND_IDLE;
      out_row_r  <= pend_v_r ? pend_row_r  : 2'd0;
      out_slot_r <= pend_v_r ? pend_slot_r : 2'd0;
      out_hnd_r  <= pend_v_r ? pend_hnd_r  : 8'd0;
      out_last_r <= 1'b1;
    end
  end

  assign in_ch.ready         = in_rdy;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.row          = out_row_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.task_handler = out_hnd_r;
  assign out_ch.last         = out_last_r;

`ifndef SYNTHESIS
  a_tok_single: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok))
    else $error("walk token held by more than one cell");

  a_wr_single: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(wr_v))
    else $error("create wrote more than one slot");

  a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (cnt_r != '0))
    else $error("pending result without a count");

  a_create_res: assert property (@(posedge clk) disable iff (!rst_n)
    create_acc |=> (out_valid_r && out_last_r && state_r == ptts_pkg::ST_IDLE))
    else $error("create request gave no final result");
`endif

endmodule

@@ verif/tb_periodic_task_tick_scheduler_top.sv @@
// Testbench: random and directed requests against a predicted task table, results checked in order.
module tb_periodic_task_tick_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        op;
    logic [1:0]  prio;
    logic [31:0] period;
    logic [31:0] delay;
    logic [7:0]  hnd;
    bit          drain;   // hold this request back until every report is in
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] row;
    logic [1:0] slot;
    logic [7:0] hnd;
    logic       last;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptts_in_if  in_ch();
  ptts_out_if out_ch();

  periodic_task_tick_scheduler_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  request_t req_backlog[$];
  report_t  report_q[$];
  int       outstanding = 0;
  int       errors = 0;
  int       sent = 0;
  int       seen_reqs = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  // predicted task table
  logic        tbl_ready[ptts_pkg::NSLOT];
  logic [31:0] tbl_period[ptts_pkg::NSLOT];
  logic [31:0] tbl_count[ptts_pkg::NSLOT];
  logic [7:0]  tbl_handler[ptts_pkg::NSLOT];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.op           = ptts_pkg::OP_CREATE;
    in_ch.priority_req = '0;
    in_ch.period       = '0;
    in_ch.first_delay  = '0;
    in_ch.handler      = '0;
    out_ch.ready       = 1'b0;
  end

  function automatic void apply_request(input logic op, input logic [1:0] prio,
                                        input logic [31:0] period,
                                        input logic [31:0] delay,
                                        input logic [7:0] hnd);
    int      idx;
    int      n;
    bit      placed;
    bit      open;
    report_t rp;
    placed = 1'b0;
    n = 0;
    if (op == ptts_pkg::OP_CREATE) begin
      if (int'(prio) < ptts_pkg::ROWS) begin
        for (int s = 0; s < ptts_pkg::SLOTS_PER_ROW; s++) begin
          idx = int'(prio) * ptts_pkg::SLOTS_PER_ROW + s;
          if (!placed && !tbl_ready[idx]) begin
            placed = 1'b1;
            tbl_ready[idx]   = 1'b1;
            tbl_period[idx]  = period;
            tbl_count[idx]   = delay;
            tbl_handler[idx] = hnd;
            rp = {ptts_pkg::KIND_CREATED, prio, 2'(s), 8'd0, 1'b1};
          end
        end
      end
      if (!placed)
        rp = {ptts_pkg::KIND_ROW_FULL, prio, 2'd0, 8'd0, 1'b1};
      report_q.push_back(rp);
    end else begin
      for (int r = 0; r < ptts_pkg::ROWS; r++) begin
        open = 1'b1;
        for (int s = 0; s < ptts_pkg::SLOTS_PER_ROW; s++) begin
          idx = r * ptts_pkg::SLOTS_PER_ROW + s;
          // a row's walk stops at its first empty slot
          if (!tbl_ready[idx])
            open = 1'b0;
          if (open) begin
            if (tbl_count[idx] == 32'd0) begin
              if (n < ptts_pkg::MAX_RESULTS) begin
                report_q.push_back({ptts_pkg::KIND_DUE, 2'(r), 2'(s), tbl_handler[idx],
                                    1'b0});
                n++;
              end
              tbl_count[idx] = tbl_period[idx] - 32'd1;
            end else begin
              tbl_count[idx] = tbl_count[idx] - 32'd1;
            end
          end
        end
      end
      if (n == 0) begin
        report_q.push_back({ptts_pkg::KIND_IDLE, 2'd0, 2'd0, 8'd0, 1'b1});
      end else begin
        rp = report_q[report_q.size() - 1];
        rp.last = 1'b1;
        report_q[report_q.size() - 1] = rp;
      end
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    request_t nxt;
    logic     gap;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      gap = !(sent >= 80 && sent < 120) && ($urandom_range(99) < 17);
      if (req_backlog.size() != 0 && !gap &&
          !(req_backlog[0].drain && (in_ch.valid || outstanding != 0))) begin
        nxt = req_backlog.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.op           <= nxt.op;
        in_ch.priority_req <= nxt.prio;
        in_ch.period       <= nxt.period;
        in_ch.first_delay  <= nxt.delay;
        in_ch.handler      <= nxt.hnd;
        sent = sent + 1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long back-pressure so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && seen_reqs >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 400;
    end
  end

  // monitor: checks results, predicts on each accepted request, paces out_ch.ready
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      for (int i = 0; i < ptts_pkg::NSLOT; i++) begin
        tbl_ready[i]   = 1'b0;
        tbl_period[i]  = '0;
        tbl_count[i]   = '0;
        tbl_handler[i] = '0;
      end
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.row, out_ch.slot, out_ch.task_handler, out_ch.last};
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d row=%0d slot=%0d handler=%0h last=%0b",
                   $time, got.kind, got.row, got.slot, got.hnd, got.last);
          errors++;
        end else begin
          want = report_q.pop_front();
          if (got.kind !== want.kind || got.row !== want.row || got.slot !== want.slot ||
              got.hnd !== want.hnd || got.last !== want.last) begin
            $display("%0t: mismatch expected kind=%0d row=%0d slot=%0d handler=%0h last=%0b",
                     $time, want.kind, want.row, want.slot, want.hnd, want.last);
            $display("%0t:          actual   kind=%0d row=%0d slot=%0d handler=%0h last=%0b",
                     $time, got.kind, got.row, got.slot, got.hnd, got.last);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_request(in_ch.op, in_ch.priority_req, in_ch.period, in_ch.first_delay,
                      in_ch.handler);
        seen_reqs <= seen_reqs + 1;
      end
      outstanding <= report_q.size();
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (seen_reqs >= 80 && seen_reqs < 120) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 17);
      end
    end
  end

  task automatic queue_create(input logic [1:0] prio, input logic [31:0] period,
                              input logic [31:0] delay, input logic [7:0] hnd);
    req_backlog.push_back('{ptts_pkg::OP_CREATE, prio, period, delay, hnd, 1'b0});
  endtask

  task automatic queue_tick(input logic [1:0] prio, input logic [31:0] pad,
                            input logic [7:0] hnd);
    req_backlog.push_back('{ptts_pkg::OP_TICK, prio, pad, pad, hnd, 1'b0});
  endtask

  initial begin
    request_t rq;
    // directed
    queue_tick(2'd0, 32'h0, 8'h00);                       // empty table: nothing due
    queue_create(2'd0, 32'd0, 32'd0, 8'h00);              // period zero
    queue_create(2'd0, 32'd1, 32'd0, 8'hFF);
    queue_create(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hA5);
    queue_create(2'd0, 32'd2, 32'd1, 8'h5A);
    queue_create(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF); // row full
    queue_create(2'd3, 32'd3, 32'd0, 8'h33);              // rows 1 and 2 empty
    queue_tick(2'd3, 32'hFFFF_FFFF, 8'hFF);               // several due
    queue_tick(2'd0, 32'h0, 8'h00);
    queue_tick(2'd1, 32'h5555_5555, 8'h55);
    queue_tick(2'd2, 32'hAAAA_AAAA, 8'hAA);
    queue_create(2'd1, 32'd1, 32'd0, 8'h11);
    queue_create(2'd2, 32'd1, 32'd2, 8'h22);
    queue_create(2'd2, 32'd4, 32'd0, 8'h23);
    queue_tick(2'd0, 32'h0, 8'h00);
    queue_tick(2'd0, 32'h0, 8'h00);
    queue_tick(2'd0, 32'h0, 8'h00);
    queue_tick(2'd0, 32'h0, 8'h00);
    // random: creates with mostly short periods and delays so tasks fall due
    for (int i = 0; i < 200; i++) begin
      rq.prio  = 2'($urandom_range(3));
      rq.hnd   = 8'($urandom_range(255));
      rq.drain = (i == 60 || i == 140);
      if ($urandom_range(99) < 30) begin
        rq.op = ptts_pkg::OP_CREATE;
        case ($urandom_range(9))
          0:       rq.period = 32'd0;
          1:       rq.period = $urandom;
          default: rq.period = 32'($urandom_range(6, 1));
        endcase
        rq.delay = ($urandom_range(4) == 0) ? $urandom : 32'($urandom_range(6));
      end else begin
        rq.op     = ptts_pkg::OP_TICK;
        rq.period = $urandom;
        rq.delay  = $urandom;
      end
      req_backlog.push_back(rq);
    end
  end

  initial begin
    #400000;
    $display("periodic_task_tick_scheduler_top verification failed");
    $finish;
  end

  initial begin
    @(posedge rst_n);
    @(negedge clk);
    while (req_backlog.size() != 0 || in_ch.valid || report_q.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
    if (report_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, report_q.size());
      errors++;
    end
    if (errors == 0)
      $display("periodic_task_tick_scheduler_top verification clean");
    else
      $display("periodic_task_tick_scheduler_top verification failed");
    $finish;
  end

endmodule
